>>> hdl/ofdr_pkg.sv
// Shared types, widths and constants for the optical-flow dead-reckoning block.
// Used by ofdr_cordic, ofdr_dot and optical_flow_dead_reckoning; no dependencies.
package ofdr_pkg;

    // Defaults for the top-level parameters
    localparam int COUNTS_PER_INCH_DEF = 8200;
    localparam int FRAC_BITS_DEF       = 16;

    // Field widths
    localparam int MUL_W   = 16;                 // counts and Q1.15 sine/cosine
    localparam int POS_W   = 32;                 // position outputs, start registers
    localparam int ANG_W   = 16;                 // binary angle
    localparam int ACC_W   = 48;                 // position accumulators
    localparam int SCALE_W = 18;                 // scale constant over the whole parameter range

    // Bit-serial multiply widths: scaled delta, and sum of two products
    localparam int DOT_AW  = MUL_W + SCALE_W + 1;
    localparam int DOT_PW  = DOT_AW + MUL_W + 1;
    localparam int RND_SH  = 15;
    localparam int RND_W   = DOT_PW - RND_SH;

    // CORDIC
    localparam int CORD_W     = 18;
    localparam int CORD_STEPS = 15;
    localparam int STEP_W     = 4;
    localparam int ATAN_W     = 14;
    localparam int CORD_INV_K = 19899;
    localparam int QUARTER    = 16384;
    localparam int HALF       = 32768;
    localparam int Q15_MAX    = 32767;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X       = 2'd0,
        CFG_START_Y       = 2'd1,
        CFG_START_HEADING = 2'd2,
        CFG_HEADING_CORR  = 2'd3
    } t_cfg_reg;

    // Arctangent table, binary angle units
    function automatic logic [ATAN_W-1:0] f_atan(input logic [STEP_W-1:0] step);
        logic [ATAN_W-1:0] v;
        unique case (step)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/ofdr_cordic.sv
// Iterative CORDIC: Q1.15 cosine and sine of a 16-bit binary angle, one step a cycle.
// Depends on ofdr_pkg.
module ofdr_cordic
    import ofdr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [ANG_W-1:0]        i_angle,
    output logic                    o_busy,
    output logic signed [MUL_W-1:0] o_cos,
    output logic signed [MUL_W-1:0] o_sin
);

    logic                     r_busy;
    logic [STEP_W-1:0]        r_step;
    logic                     r_flip;
    logic signed [CORD_W-1:0] r_x, r_y, r_z;

    logic signed [CORD_W-1:0] w_a0, w_a, w_xs, w_ys, w_at, w_xo, w_yo;
    logic                     w_flip;

    // Fold the angle into a half turn around zero
    always_comb begin
        w_a0   = CORD_W'(signed'(i_angle));
        w_a    = w_a0;
        w_flip = 1'b0;
        if (w_a0 > CORD_W'(QUARTER)) begin
            w_a    = w_a0 - CORD_W'(HALF);
            w_flip = 1'b1;
        end else if (w_a0 < -CORD_W'(QUARTER)) begin
            w_a    = w_a0 + CORD_W'(HALF);
            w_flip = 1'b1;
        end
    end

    assign w_xs = r_x >>> r_step;
    assign w_ys = r_y >>> r_step;
    assign w_at = CORD_W'(f_atan(r_step));

    // One rotation step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_flip <= w_flip;
            r_x    <= CORD_W'(CORD_INV_K);
            r_y    <= '0;
            r_z    <= w_a;
        end else if (r_busy) begin
            if (!r_z[CORD_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(CORD_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Undo the fold and clamp to the Q1.15 range
    assign w_xo = r_flip ? -r_x : r_x;
    assign w_yo = r_flip ? -r_y : r_y;

    always_comb begin
        if (w_xo > CORD_W'(Q15_MAX))       o_cos = MUL_W'(Q15_MAX);
        else if (w_xo < -CORD_W'(Q15_MAX)) o_cos = -MUL_W'(Q15_MAX);
        else                               o_cos = w_xo[MUL_W-1:0];
        if (w_yo > CORD_W'(Q15_MAX))       o_sin = MUL_W'(Q15_MAX);
        else if (w_yo < -CORD_W'(Q15_MAX)) o_sin = -MUL_W'(Q15_MAX);
        else                               o_sin = w_yo[MUL_W-1:0];
    end

    assign o_busy = r_busy;

endmodule

>>> hdl/ofdr_dot.sv
// Bit-serial signed dot product a0*b0 + a1*b1, one multiplier bit per cycle, MSB first.
// Depends on ofdr_pkg.
module ofdr_dot
    import ofdr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DOT_AW-1:0] i_a0,
    input  logic signed [DOT_AW-1:0] i_a1,
    input  logic signed [MUL_W-1:0]  i_b0,
    input  logic signed [MUL_W-1:0]  i_b1,
    output logic                     o_busy,
    output logic signed [DOT_PW-1:0] o_result
);

    localparam int CNT_W = $clog2(MUL_W);

    logic                     r_busy;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [DOT_AW-1:0] r_a0, r_a1;
    logic [MUL_W-1:0]         r_b0, r_b1;
    logic signed [DOT_PW-1:0] r_acc;

    logic signed [DOT_PW-1:0] w_t0, w_t1, w_term;

    // Partial products of the current multiplier bits; the sign bit weighs negative
    always_comb begin
        w_t0   = r_b0[MUL_W-1] ? {{(DOT_PW-DOT_AW){r_a0[DOT_AW-1]}}, r_a0} : '0;
        w_t1   = r_b1[MUL_W-1] ? {{(DOT_PW-DOT_AW){r_a1[DOT_AW-1]}}, r_a1} : '0;
        w_term = w_t0 + w_t1;
        if (r_cnt == '0) begin
            w_term = -w_term;
        end
    end

    // Double and add, shift the multipliers up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_a0   <= i_a0;
            r_a1   <= i_a1;
            r_b0   <= i_b0;
            r_b1   <= i_b1;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[DOT_PW-2:0], 1'b0} + w_term;
            r_b0  <= {r_b0[MUL_W-2:0], 1'b0};
            r_b1  <= {r_b1[MUL_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(MUL_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_result = r_acc;

endmodule

>>> hdl/optical_flow_dead_reckoning.sv
// Optical-flow dead reckoning. Each item passes from acceptance to the result register
// through two bit-serial multiply passes (counts times the scale
// constant, then the rotation by cosine and sine, with the 15-step CORDIC running
// alongside the first pass), then an accumulate and an output state. A restart item
// skips both passes. One item is worked on at a time; the next is accepted as soon as the
// result sits in the output register, even if it has not been taken yet.
// Depends on ofdr_pkg, ofdr_cordic and ofdr_dot.
module optical_flow_dead_reckoning
    import ofdr_pkg::*;
#(
    parameter int COUNTS_PER_INCH = COUNTS_PER_INCH_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,  // delta_x_counts, delta_y_counts, gyro_yaw
    input  logic                 s_axis_tuser,  // restart
    // Result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [79:0]          m_axis_tdata,  // position_x, position_y, heading
    // Configuration writes
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [POS_W-1:0]     i_cfg_data
);

    localparam int unsigned SCALE_VAL =
        ((254 * (1 << FRAC_BITS)) + COUNTS_PER_INCH / 2) / COUNTS_PER_INCH;
    localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(SCALE_VAL);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ROT,
        ST_ACC,
        ST_OUT
    } t_state;

    t_state                     r_state;
    logic signed [POS_W-1:0]    r_start_x, r_start_y;
    logic [ANG_W-1:0]           r_start_heading, r_heading_corr;
    logic signed [ACC_W-1:0]    r_acc_x, r_acc_y;
    logic [ANG_W-1:0]           r_heading;
    logic                       r_restart;
    logic                       r_out_valid;
    logic [79:0]                r_out_data;

    logic                       w_accept, w_scale_start, w_rot_start;
    logic [ANG_W-1:0]           w_heading;
    logic                       w_cord_busy, w_dot_x_busy, w_dot_y_busy;
    logic signed [MUL_W-1:0]    w_cos, w_sin, w_nsin;
    logic signed [DOT_PW-1:0]   w_res_x, w_res_y;
    logic signed [DOT_AW-1:0]   w_a0_x, w_a1_x, w_a0_y, w_a1_y;
    logic signed [MUL_W-1:0]    w_b0_x, w_b1_x, w_b0_y, w_b1_y;
    logic signed [ACC_W-1:0]    n_acc_x, n_acc_y;

    // Round a rotated product to 0.1 mm fraction units and add it with saturation
    function automatic logic signed [ACC_W-1:0] f_acc_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [DOT_PW-1:0] prod
    );
        logic signed [DOT_PW-1:0] rnd;
        logic signed [ACC_W:0]    sum;
        logic signed [ACC_W-1:0]  res;
        rnd = prod + DOT_PW'(1 << (RND_SH - 1));
        sum = {acc[ACC_W-1], acc}
            + {{(ACC_W + 1 - RND_W){rnd[DOT_PW-1]}}, rnd[DOT_PW-1:RND_SH]};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            res = sum[ACC_W-1:0];
        end
        return res;
    endfunction

    // Drop the fraction bits and saturate to 32 bits
    function automatic logic [POS_W-1:0] f_out32(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        logic [POS_W-1:0]        res;
        v = acc >>> FRAC_BITS;
        if (v[ACC_W-1:POS_W-1] == '0 || v[ACC_W-1:POS_W-1] == '1) begin
            res = v[POS_W-1:0];
        end else begin
            res = v[ACC_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        return res;
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_heading     = ANG_W'(s_axis_tdata[47:32] - r_start_heading + r_heading_corr);
    assign w_scale_start = w_accept && !s_axis_tuser;
    assign w_rot_start   = (r_state == ST_SCALE) && !w_cord_busy
                           && !w_dot_x_busy && !w_dot_y_busy;
    assign w_nsin        = -w_sin;

    // Operand select: scale pass, then rotation pass on the scaled deltas
    always_comb begin
        if (r_state == ST_IDLE) begin
            w_a0_x = {{(DOT_AW-SCALE_W){1'b0}}, SCALE};
            w_a1_x = '0;
            w_b0_x = s_axis_tdata[15:0];
            w_b1_x = '0;
            w_a0_y = {{(DOT_AW-SCALE_W){1'b0}}, SCALE};
            w_a1_y = '0;
            w_b0_y = s_axis_tdata[31:16];
            w_b1_y = '0;
        end else begin
            w_a0_x = w_res_x[DOT_AW-1:0];
            w_a1_x = w_res_y[DOT_AW-1:0];
            w_b0_x = w_cos;
            w_b1_x = w_nsin;
            w_a0_y = w_res_x[DOT_AW-1:0];
            w_a1_y = w_res_y[DOT_AW-1:0];
            w_b0_y = w_sin;
            w_b1_y = w_cos;
        end
    end

    ofdr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scale_start),
        .i_angle (w_heading),
        .o_busy  (w_cord_busy),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    ofdr_dot u_dot_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_scale_start || w_rot_start),
        .i_a0     (w_a0_x),
        .i_a1     (w_a1_x),
        .i_b0     (w_b0_x),
        .i_b1     (w_b1_x),
        .o_busy   (w_dot_x_busy),
        .o_result (w_res_x)
    );

    ofdr_dot u_dot_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_scale_start || w_rot_start),
        .i_a0     (w_a0_y),
        .i_a1     (w_a1_y),
        .i_b0     (w_b0_y),
        .i_b1     (w_b1_y),
        .o_busy   (w_dot_y_busy),
        .o_result (w_res_y)
    );

    // Next accumulator values: load the start position or add the rotated step
    always_comb begin
        if (r_restart) begin
            n_acc_x = {{(ACC_W-POS_W){r_start_x[POS_W-1]}}, r_start_x} << FRAC_BITS;
            n_acc_y = {{(ACC_W-POS_W){r_start_y[POS_W-1]}}, r_start_y} << FRAC_BITS;
        end else begin
            n_acc_x = f_acc_add(r_acc_x, w_res_x);
            n_acc_y = f_acc_add(r_acc_y, w_res_y);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x       <= '0;
            r_start_y       <= '0;
            r_start_heading <= '0;
            r_heading_corr  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_START_X:       r_start_x       <= i_cfg_data;
                CFG_START_Y:       r_start_y       <= i_cfg_data;
                CFG_START_HEADING: r_start_heading <= i_cfg_data[ANG_W-1:0];
                CFG_HEADING_CORR:  r_heading_corr  <= i_cfg_data[ANG_W-1:0];
            endcase
        end
    end

    // Sequencer, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_heading <= w_heading;
                        r_restart <= s_axis_tuser;
                        r_state   <= s_axis_tuser ? ST_ACC : ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    if (w_rot_start) begin
                        r_state <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    if (!w_dot_x_busy && !w_dot_y_busy) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    r_acc_x <= n_acc_x;
                    r_acc_y <= n_acc_y;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= {r_heading, f_out32(r_acc_y), f_out32(r_acc_x)};
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // An accepted item always starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != ST_IDLE)
        else $error("sequencer stayed idle after an accepted item");

    // No arithmetic unit runs while the block waits for an item
    a_idle_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !w_cord_busy && !w_dot_x_busy && !w_dot_y_busy)
        else $error("arithmetic unit busy while idle");

    // The rotation pass only starts from settled cosine and sine
    a_rot_after_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROT |-> !w_cord_busy)
        else $error("rotation running before the CORDIC finished");

    // A restart loads the start x position exactly
    a_restart_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ACC && r_restart |=>
            r_acc_x == ({{(ACC_W-POS_W){$past(r_start_x[POS_W-1])}}, $past(r_start_x)}
                        << FRAC_BITS))
        else $error("restart did not load the start x position");

endmodule

>>> sim/tb_optical_flow_dead_reckoning.sv
// Self-checking testbench for optical_flow_dead_reckoning: directed table, then random samples
// under several register settings, scored against a behavioral dead-reckoning predictor.
// Depends on ofdr_pkg and the optical_flow_dead_reckoning RTL.
`timescale 1ns / 1ps

module tb_optical_flow_dead_reckoning;
    import ofdr_pkg::*;

    // Predictor constants
    localparam longint DIST_SCALE = ((longint'(254) << FRAC_BITS_DEF)
                                     + COUNTS_PER_INCH_DEF / 2) / COUNTS_PER_INCH_DEF;
    localparam longint ACC_TOP    = (longint'(1) << 47) - 1;
    localparam longint ACC_BOT    = -ACC_TOP - 1;
    localparam longint OUT_TOP    = 64'sd2147483647;
    localparam longint OUT_BOT    = -64'sd2147483648;
    localparam int     STALL_MAX  = 3000;
    localparam int     MAX_REPORT = 10;

    typedef struct packed {
        logic [15:0] hd;
        logic [31:0] py;
        logic [31:0] px;
    } t_fix;

    typedef struct {
        bit          is_cfg;
        t_cfg_reg    reg_idx;
        logic [31:0] reg_val;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] yaw;
        logic        rs;
        bit          typed;
        t_fix        want;
    } t_row;

    // Clock, reset and block ports
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata  = '0;  // delta_x_counts, delta_y_counts, gyro_yaw
    logic              s_axis_tuser  = 1'b0; // restart
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [79:0]       m_axis_tdata;        // position_x, position_y, heading
    logic              i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [POS_W-1:0]  i_cfg_data    = '0;

    // Predictor state and register shadows
    longint      acc_x, acc_y;
    longint      org_x, org_y;
    logic [15:0] yaw_zero, yaw_trim;
    int          angle_step [0:14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                       41, 20, 10, 5, 3, 1, 1};

    t_fix pos_due [$];
    t_row dir_tbl [$];
    int   bad_count   = 0;
    int   n_sent      = 0;
    int   quiet_cycles = 0;
    bit   calm        = 1'b0;
    bit   held        = 1'b0;

    always #6 i_clk = ~i_clk;

    optical_flow_dead_reckoning uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Q1.15 cosine and sine of a binary angle by 15-step CORDIC
    function automatic void sin_cos(input logic [15:0] ang, output longint c, output longint s);
        longint a, x, y, z, xs, ys;
        bit     flip;
        a    = longint'($signed(ang));
        flip = 1'b0;
        x    = CORD_INV_K;
        y    = 0;
        if (a > QUARTER) begin
            a    = a - HALF;
            flip = 1'b1;
        end else if (a < -QUARTER) begin
            a    = a + HALF;
            flip = 1'b1;
        end
        z = a;
        for (int i = 0; i < 15; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - angle_step[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + angle_step[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = (x > Q15_MAX) ? Q15_MAX : ((x < -Q15_MAX) ? -Q15_MAX : x);
        s = (y > Q15_MAX) ? Q15_MAX : ((y < -Q15_MAX) ? -Q15_MAX : y);
    endfunction

    function automatic longint clamp_acc(input longint v);
        return (v > ACC_TOP) ? ACC_TOP : ((v < ACC_BOT) ? ACC_BOT : v);
    endfunction

    function automatic logic [31:0] whole_units(input longint acc);
        longint v;
        v = acc >>> FRAC_BITS_DEF;
        if (v > OUT_TOP) v = OUT_TOP;
        if (v < OUT_BOT) v = OUT_BOT;
        return v[31:0];
    endfunction

    // Advance the position estimate by one sample and return the reported position
    function automatic t_fix track_sample(input logic [15:0] dx, input logic [15:0] dy,
                                          input logic [15:0] yaw, input logic rs);
        t_fix        r;
        logic [15:0] hd;
        longint      sx, sy, c, s, rx, ry;
        hd = yaw - yaw_zero + yaw_trim;
        if (rs) begin
            acc_x = org_x * (longint'(1) << FRAC_BITS_DEF);
            acc_y = org_y * (longint'(1) << FRAC_BITS_DEF);
        end else begin
            sx = longint'($signed(dx)) * DIST_SCALE;
            sy = longint'($signed(dy)) * DIST_SCALE;
            sin_cos(hd, c, s);
            rx = (sx * c - sy * s + 16384) >>> 15;
            ry = (sx * s + sy * c + 16384) >>> 15;
            acc_x = clamp_acc(acc_x + rx);
            acc_y = clamp_acc(acc_y + ry);
        end
        r.px = whole_units(acc_x);
        r.py = whole_units(acc_y);
        r.hd = hd;
        return r;
    endfunction

    // Table rows
    function automatic t_row item_row(input logic [15:0] dx, input logic [15:0] dy,
                                      input logic [15:0] yaw, input logic rs);
        t_row r;
        r.reg_val = '0;
        r.want    = '0;
        r.is_cfg  = 1'b0;
        r.reg_idx = CFG_START_X;
        r.dx      = dx;
        r.dy      = dy;
        r.yaw     = yaw;
        r.rs      = rs;
        r.typed   = 1'b0;
        return r;
    endfunction

    function automatic t_row known_row(input logic [15:0] dx, input logic [15:0] dy,
                                       input logic [15:0] yaw, input logic rs,
                                       input logic [31:0] px, input logic [31:0] py,
                                       input logic [15:0] hd);
        t_row r;
        r         = item_row(dx, dy, yaw, rs);
        r.typed   = 1'b1;
        r.want.px = px;
        r.want.py = py;
        r.want.hd = hd;
        return r;
    endfunction

    function automatic t_row cfg_row(input t_cfg_reg idx, input logic [31:0] v);
        t_row r;
        r         = item_row('0, '0, '0, 1'b0);
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = v;
        return r;
    endfunction

    // Random field values, weighted toward extremes and quadrant boundaries
    function automatic logic [15:0] pick_delta();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'h7FFF;
                    1:       v = 16'h8000;
                    2:       v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            1, 2: v = 16'($urandom_range(0, 128)) - 16'd64;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_yaw();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'h4000 + 16'($urandom_range(0, 2)) - 16'd1;
            1: v = 16'hC000 + 16'($urandom_range(0, 2)) - 16'd1;
            2: v = 16'h8000 + 16'($urandom_range(0, 2)) - 16'd1;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // Drop valid and hold until every pending result is out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pos_due.size() != 0);
    endtask

    // Drive one register write; the caller lowers the enable after the last one
    task automatic cfg_write(input t_cfg_reg idx, input logic [31:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= v;
        case (idx)
            CFG_START_X:       org_x    = longint'($signed(v));
            CFG_START_Y:       org_y    = longint'($signed(v));
            CFG_START_HEADING: yaw_zero = v[15:0];
            CFG_HEADING_CORR:  yaw_trim = v[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offer one item, wait for acceptance, then queue its expected position
    task automatic push_item(input logic [15:0] dx, input logic [15:0] dy,
                             input logic [15:0] yaw, input logic rs,
                             input bit typed, input t_fix want);
        t_fix calc;
        s_axis_tdata  <= {yaw, dy, dx};
        s_axis_tuser  <= rs;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        calc = track_sample(dx, dy, yaw, rs);
        pos_due.push_back(typed ? want : calc);
        n_sent++;
    endtask

    task automatic idle_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic flag_mismatch(input string msg);
        bad_count++;
        if (bad_count <= MAX_REPORT) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // Directed table
    initial begin
        // Reset values
        dir_tbl.push_back(known_row(16'h0000, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0, 16'h0000));
        dir_tbl.push_back(known_row(16'h7FFF, 16'h8000, 16'h1234, 1'b1, 32'h0, 32'h0, 16'h1234));
        dir_tbl.push_back(item_row(16'h7FFF, 16'h0000, 16'h0000, 1'b0));
        dir_tbl.push_back(item_row(16'h8000, 16'h8000, 16'h4000, 1'b0));
        dir_tbl.push_back(item_row(16'h0001, 16'hFFFF, 16'h8000, 1'b0));
        dir_tbl.push_back(item_row(16'h8000, 16'h7FFF, 16'hC000, 1'b0));
        dir_tbl.push_back(item_row(16'd12345, 16'hFFCA, 16'hFFFF, 1'b0));
        dir_tbl.push_back(item_row(16'h7FFF, 16'h7FFF, 16'h4001, 1'b0));
        dir_tbl.push_back(item_row(16'h8000, 16'h0001, 16'hBFFF, 1'b0));
        // Start at the positive x and negative y corner, drive into saturation
        dir_tbl.push_back(cfg_row(CFG_START_X, 32'h7FFF_FFFF));
        dir_tbl.push_back(cfg_row(CFG_START_Y, 32'h8000_0000));
        dir_tbl.push_back(cfg_row(CFG_START_HEADING, 32'h0000_FFFF));
        dir_tbl.push_back(cfg_row(CFG_HEADING_CORR, 32'h0000_0000));
        dir_tbl.push_back(known_row(16'h1111, 16'h2222, 16'hFFFF, 1'b1,
                                    32'h7FFF_FFFF, 32'h8000_0000, 16'h0000));
        dir_tbl.push_back(known_row(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0,
                                    32'h7FFF_FFFF, 32'h8000_0000, 16'h0000));
        dir_tbl.push_back(item_row(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0));
        // Opposite corner, heading wraps through the correction
        dir_tbl.push_back(cfg_row(CFG_START_X, 32'h8000_0000));
        dir_tbl.push_back(cfg_row(CFG_START_Y, 32'h7FFF_FFFF));
        dir_tbl.push_back(cfg_row(CFG_START_HEADING, 32'h0000_0000));
        dir_tbl.push_back(cfg_row(CFG_HEADING_CORR, 32'h0000_FFFF));
        dir_tbl.push_back(known_row(16'h0000, 16'h0000, 16'h0001, 1'b1,
                                    32'h8000_0000, 32'h7FFF_FFFF, 16'h0000));
        dir_tbl.push_back(known_row(16'h8000, 16'h7FFF, 16'h0001, 1'b0,
                                    32'h8000_0000, 32'h7FFF_FFFF, 16'h0000));
        dir_tbl.push_back(known_row(16'h0000, 16'h0000, 16'h8001, 1'b0,
                                    32'h8000_0000, 32'h7FFF_FFFF, 16'h8000));
        // Mid-range offsets
        dir_tbl.push_back(cfg_row(CFG_START_X, 32'h0000_0000));
        dir_tbl.push_back(cfg_row(CFG_START_Y, 32'h0000_0000));
        dir_tbl.push_back(cfg_row(CFG_START_HEADING, 32'h0000_1000));
        dir_tbl.push_back(cfg_row(CFG_HEADING_CORR, 32'h0000_2345));
        dir_tbl.push_back(known_row(16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h0, 32'h0, 16'h1345));
        dir_tbl.push_back(item_row(16'hFFFF, 16'h0001, 16'h7FFF, 1'b0));
        dir_tbl.push_back(item_row(16'h5555, 16'h2AAA, 16'hAAAA, 1'b0));
        dir_tbl.push_back(item_row(16'hAAAA, 16'h5555, 16'h5555, 1'b0));
        dir_tbl.push_back(item_row(16'h0F0F, 16'hF0F0, 16'hFFFF, 1'b1));
    end

    // Stimulus
    initial begin
        t_fix        none;
        logic [31:0] sx, sy, sh, hc;
        none     = '0;
        acc_x    = 0;
        acc_y    = 0;
        org_x    = 0;
        org_y    = 0;
        yaw_zero = '0;
        yaw_trim = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int k = 0; k < dir_tbl.size(); k++) begin
            if (dir_tbl[k].is_cfg) begin
                if (k == 0 || !dir_tbl[k-1].is_cfg) wait_idle();
                cfg_write(dir_tbl[k].reg_idx, dir_tbl[k].reg_val);
                if (k + 1 == dir_tbl.size() || !dir_tbl[k+1].is_cfg) i_cfg_wr_en <= 1'b0;
            end else begin
                push_item(dir_tbl[k].dx, dir_tbl[k].dy, dir_tbl[k].yaw, dir_tbl[k].rs,
                          dir_tbl[k].typed, dir_tbl[k].want);
                idle_gap();
            end
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    sx = $urandom;
                    sy = $urandom;
                    sh = $urandom_range(0, 65535);
                    hc = $urandom_range(0, 65535);
                end
                1: begin
                    sx = 32'h8000_0000;
                    sy = 32'h7FFF_FFFF;
                    sh = 32'h0000_FFFF;
                    hc = 32'h0000_0000;
                end
                2: begin
                    sx = 32'h7FFF_FFFF;
                    sy = 32'h8000_0000;
                    sh = 32'h0000_0000;
                    hc = 32'h0000_FFFF;
                end
                default: begin
                    sx = $urandom_range(0, 20000) - 10000;
                    sy = $urandom_range(0, 20000) - 10000;
                    sh = $urandom_range(0, 65535);
                    hc = $urandom_range(0, 65535);
                end
            endcase
            wait_idle();
            cfg_write(CFG_START_X, sx);
            cfg_write(CFG_START_Y, sy);
            cfg_write(CFG_START_HEADING, sh);
            cfg_write(CFG_HEADING_CORR, hc);
            i_cfg_wr_en <= 1'b0;

            for (int k = 0; k < 205; k++) begin
                if (p == 3 && k >= 125) calm = 1'b1;
                // Sender pause until the block has fully drained
                if (p == 1 && k == 100) wait_idle();
                push_item(pick_delta(), pick_delta(), pick_yaw(),
                          (k == 0) || ($urandom_range(0, 19) == 0), 1'b0, none);
                idle_gap();
            end
        end

        // Drain and let any stray result show up
        s_axis_tvalid <= 1'b0;
        while (pos_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (bad_count == 0 && pos_due.size() == 0) begin
            $display("optical_flow_dead_reckoning regression: pass");
        end else begin
            $display("optical_flow_dead_reckoning regression: fail");
        end
        $finish;
    end

    // Result sink: random stalls, one long hold-off, always ready near the end
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && n_sent >= 300) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (150) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Compare each taken result with the oldest expected position
    always @(posedge i_clk) begin
        t_fix got, w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pos_due.size() == 0) begin
                flag_mismatch($sformatf("result with nothing pending: x=%0d y=%0d hd=%h",
                                        $signed(got.px), $signed(got.py), got.hd));
            end else begin
                w = pos_due.pop_front();
                if (got.px !== w.px || got.py !== w.py || got.hd !== w.hd) begin
                    flag_mismatch($sformatf("exp x=%0d y=%0d hd=%h, got x=%0d y=%0d hd=%h",
                                            $signed(w.px), $signed(w.py), w.hd,
                                            $signed(got.px), $signed(got.py), got.hd));
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_MAX) begin
            $display("timeout: no item moved for %0d cycles", STALL_MAX);
            $display("optical_flow_dead_reckoning regression: fail");
            $finish;
        end
    end

endmodule
